// ===== sv/mecanum_wheel_pwm_mixer_top_defines.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef MECANUM_WHEEL_PWM_MIXER_TOP_DEFINES_SVH
`define MECANUM_WHEEL_PWM_MIXER_TOP_DEFINES_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define MWPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mwpm assertion failed");
// Expression must never be true outside reset.
`define MWPM_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mwpm forbidden condition");
`else
`define MWPM_ASSERT(lbl, prop)
`define MWPM_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== sv/mwpm_pkg.sv =====
// Types and constants of the mecanum wheel PWM mixer.
package mwpm_pkg;
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 25;
  localparam int SPEED_W   = 24;
  localparam int PWM_W     = 16;
  localparam int CFG_W     = 32;
  localparam int IN_DATA_W = 184;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [2:0] {
    OP_BODY   = 3'd0,
    OP_WHEELS = 3'd1,
    OP_TIME   = 3'd2,
    OP_ENABLE = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_RADIUS   = 3'd0,
    REG_LEVER    = 3'd1,
    REG_MAXSPD   = 3'd2,
    REG_FULL     = 3'd3,
    REG_DEADBAND = 3'd4,
    REG_TIMEOUT  = 3'd5,
    REG_INVERT   = 3'd6
  } reg_e;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [15:0] RST_RADIUS   = 16'd3277;
  localparam logic [17:0] RST_LEVER    = 18'd14418;
  localparam logic [22:0] RST_MAXSPD   = 23'd7680;
  localparam logic [15:0] RST_FULL     = 16'd999;
  localparam logic [15:0] RST_DEADBAND = 16'd0;
  localparam logic [31:0] RST_TIMEOUT  = 32'd2000;
  localparam logic [3:0]  RST_INVERT   = 4'd0;
endpackage

// ===== sv/mwpm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mwpm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mwpm_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [mwpm_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                            done_o,
  output logic [mwpm_pkg::DIV_NUM_W-1:0]  quo_o
);
  import mwpm_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse after the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(DIV_NUM_W - 1));
      if (start_i) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        num_q <= {num_q[DIV_NUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

// ===== sv/mecanum_wheel_pwm_mixer_top.sv =====
// Top level of the mecanum wheel PWM mixer.
// Takes one command transaction at a time and returns at most one result
// transaction with four PWM counts, four directions and the watchdog flag.
// A result waiting in the output register holds the finished transaction
// back until the receiver takes it. Body velocity and wheel speed commands
// use the shared 40 bit restoring divider, one quotient bit per cycle: four
// times for the mixing divide by radius (body velocity only) and four times
// for the PWM scaling while enabled with a nonzero common divisor.
// The input is ready whenever the sequencer is idle, also while a finished
// result still waits in the output register. Configuration is written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do so only while the
// block is idle, as the block itself does not enforce it.
`include "mecanum_wheel_pwm_mixer_top_defines.svh"
module mecanum_wheel_pwm_mixer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [mwpm_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // vel_x, vel_y, yaw_rate, speed_lf, speed_rf, speed_lr, speed_rr, now_ms,
  // enable_value, zero pad
  input  logic [mwpm_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // op
  input  logic [2:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pwm_lf, pwm_rf, pwm_lr, pwm_rr, dir_lf, dir_rf, dir_lr, dir_rr,
  // watchdog_tripped, zero pad
  output logic [mwpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import mwpm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_MIX_LOAD, ST_MIX_WAIT, ST_CMD,
    ST_PMUL, ST_PLOAD, ST_PWAIT, ST_FIN
  } state_e;

  // configuration
  logic [15:0] radius_q, full_q, deadband_q;
  logic [17:0] lever_q;
  logic [22:0] maxspd_q;
  logic [31:0] timeout_q;
  logic [3:0]  invert_q;

  // persistent state
  logic        enabled_q, trip_q;
  logic [31:0] last_q;

  // working registers
  state_e                    state_q;
  logic [1:0]                idx_q;
  logic signed [15:0]        vx_q, vy_q, wz_q;
  logic signed [34:0]        rot_q;
  logic [31:0]               now_q;
  logic signed [SPEED_W-1:0] w_q [4];
  logic [SPEED_W-1:0]        d_q;
  logic [DIV_NUM_W-1:0]      prod_q;
  logic                      neg_q;
  logic                      div_start_q;
  logic [DIV_NUM_W-1:0]      div_num_q;
  logic [DIV_DEN_W-1:0]      div_den_q;
  logic [PWM_W-1:0]          res_pwm_q [4];
  logic [1:0]                res_dir_q [4];
  logic                      res_trip_q;
  logic                      m_valid_q;
  logic [OUT_DATA_W-1:0]     m_data_q;

  logic                      div_done;
  logic [DIV_NUM_W-1:0]      div_quo;

  // result moves into the output register this cycle
  logic                      out_load;
  assign out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);

  // input unpack
  logic s_accept;
  op_e  in_op;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = op_e'(s_axis_tuser_i);

  // mixing for the current wheel: n = lin*2^16 +/- lever*wz
  logic signed [16:0] lin;
  logic signed [35:0] n_mix;
  logic [35:0]        mag_mix;
  logic [15:0]        radius_eff;
  logic [DIV_NUM_W-1:0] mix_num;
  logic [DIV_DEN_W-1:0] mix_den;
  always_comb begin
    if (idx_q[0] ^ idx_q[1]) lin = 17'(vx_q) + 17'(vy_q);
    else                     lin = 17'(vx_q) - 17'(vy_q);
    if (idx_q[0]) n_mix = {{3{lin[16]}}, lin, 16'b0} + 36'(rot_q);
    else          n_mix = {{3{lin[16]}}, lin, 16'b0} - 36'(rot_q);
    mag_mix    = n_mix[35] ? 36'(-n_mix) : 36'(n_mix);
    radius_eff = (radius_q == '0) ? 16'd1 : radius_q;
    mix_den    = DIV_DEN_W'({radius_eff, 4'b0});
    mix_num    = DIV_NUM_W'(mag_mix) + DIV_NUM_W'({radius_eff, 3'b0});
  end

  // wheel magnitudes and common divisor
  logic [SPEED_W-1:0] mag [4];
  logic [SPEED_W-1:0] big01, big23, largest, d_sel;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = w_q[i][SPEED_W-1] ? SPEED_W'(-w_q[i]) : SPEED_W'(w_q[i]);
    end
    big01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    big23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    largest = (big01 > big23) ? big01 : big23;
    d_sel   = (SPEED_W'(maxspd_q) > largest) ? SPEED_W'(maxspd_q) : largest;
  end

  // saturated mixed speed from the quotient
  logic signed [SPEED_W-1:0] mix_sat;
  always_comb begin
    if (neg_q) begin
      if (div_quo > DIV_NUM_W'(24'h800000)) mix_sat = 24'sh800000;
      else mix_sat = SPEED_W'(-div_quo[SPEED_W-1:0]);
    end else begin
      if (div_quo > DIV_NUM_W'(24'h7FFFFF)) mix_sat = 24'sh7FFFFF;
      else mix_sat = div_quo[SPEED_W-1:0];
    end
  end

  // PWM count and direction from the quotient
  logic [PWM_W-1:0] pwm_val;
  logic [1:0]       dir_val;
  logic             fwd;
  always_comb begin
    pwm_val = (|div_quo[DIV_NUM_W-1:PWM_W]) ? '1 : div_quo[PWM_W-1:0];
    if (pwm_val < deadband_q) pwm_val = '0;
    fwd = !w_q[idx_q][SPEED_W-1] ^ invert_q[idx_q];
    if (pwm_val == '0) dir_val = DIR_STOP;
    else dir_val = fwd ? DIR_FWD : DIR_REV;
  end

  logic [31:0] elapsed;
  assign elapsed = s_axis_tdata_i[175:144] - last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RST_RADIUS;
      lever_q     <= RST_LEVER;
      maxspd_q    <= RST_MAXSPD;
      full_q      <= RST_FULL;
      deadband_q  <= RST_DEADBAND;
      timeout_q   <= RST_TIMEOUT;
      invert_q    <= RST_INVERT;
      enabled_q   <= 1'b1;
      trip_q      <= 1'b0;
      last_q      <= '0;
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      // divider start pulse is registered together with its operands in the load states
      div_start_q <= (state_q == ST_MIX_LOAD) || (state_q == ST_PLOAD && d_q != '0);
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;

      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_RADIUS:   radius_q   <= cfg_wdata_i[15:0];
          REG_LEVER:    lever_q    <= cfg_wdata_i[17:0];
          REG_MAXSPD:   maxspd_q   <= cfg_wdata_i[22:0];
          REG_FULL:     full_q     <= cfg_wdata_i[15:0];
          REG_DEADBAND: deadband_q <= cfg_wdata_i[15:0];
          REG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
          REG_INVERT:   invert_q   <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            now_q <= s_axis_tdata_i[175:144];
            case (in_op)
              OP_BODY: begin
                vx_q    <= s_axis_tdata_i[15:0];
                vy_q    <= s_axis_tdata_i[31:16];
                wz_q    <= s_axis_tdata_i[47:32];
                state_q <= ST_MUL;
              end
              OP_WHEELS: begin
                w_q[0]  <= s_axis_tdata_i[71:48];
                w_q[1]  <= s_axis_tdata_i[95:72];
                w_q[2]  <= s_axis_tdata_i[119:96];
                w_q[3]  <= s_axis_tdata_i[143:120];
                state_q <= ST_CMD;
              end
              OP_TIME: begin
                if (timeout_q != '0 && elapsed >= timeout_q) begin
                  trip_q <= 1'b1;
                  for (int i = 0; i < 4; i++) begin
                    res_pwm_q[i] <= '0;
                    res_dir_q[i] <= DIR_STOP;
                  end
                  res_trip_q <= 1'b1;
                  state_q    <= ST_FIN;
                end
              end
              OP_ENABLE: begin
                enabled_q <= s_axis_tdata_i[176];
                if (!s_axis_tdata_i[176]) begin
                  for (int i = 0; i < 4; i++) begin
                    res_pwm_q[i] <= '0;
                    res_dir_q[i] <= DIR_STOP;
                  end
                  res_trip_q <= trip_q;
                  state_q    <= ST_FIN;
                end
              end
              OP_STOP: begin
                for (int i = 0; i < 4; i++) begin
                  res_pwm_q[i] <= '0;
                  res_dir_q[i] <= DIR_STOP;
                end
                res_trip_q <= trip_q;
                state_q    <= ST_FIN;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          rot_q   <= $signed({1'b0, lever_q}) * wz_q;
          idx_q   <= '0;
          state_q <= ST_MIX_LOAD;
        end
        ST_MIX_LOAD: begin
          neg_q     <= n_mix[35];
          div_num_q <= mix_num;
          div_den_q <= mix_den;
          state_q   <= ST_MIX_WAIT;
        end
        ST_MIX_WAIT: begin
          if (div_done) begin
            w_q[idx_q] <= mix_sat;
            idx_q      <= idx_q + 1'b1;
            state_q    <= (idx_q == 2'd3) ? ST_CMD : ST_MIX_LOAD;
          end
        end
        ST_CMD: begin
          last_q     <= now_q;
          trip_q     <= 1'b0;
          res_trip_q <= 1'b0;
          d_q        <= d_sel;
          idx_q      <= '0;
          if (!enabled_q) begin
            for (int i = 0; i < 4; i++) begin
              res_pwm_q[i] <= '0;
              res_dir_q[i] <= DIR_STOP;
            end
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          prod_q  <= mag[idx_q] * full_q;
          state_q <= ST_PLOAD;
        end
        ST_PLOAD: begin
          if (d_q == '0) begin
            // zero divisor: count zero, wheel stopped
            res_pwm_q[idx_q] <= '0;
            res_dir_q[idx_q] <= DIR_STOP;
            idx_q            <= idx_q + 1'b1;
            state_q          <= (idx_q == 2'd3) ? ST_FIN : ST_PMUL;
          end else begin
            div_num_q <= {prod_q[DIV_NUM_W-2:0], 1'b0} + DIV_NUM_W'(d_q);
            div_den_q <= {d_q, 1'b0};
            state_q   <= ST_PWAIT;
          end
        end
        ST_PWAIT: begin
          if (div_done) begin
            res_pwm_q[idx_q] <= pwm_val;
            res_dir_q[idx_q] <= dir_val;
            idx_q            <= idx_q + 1'b1;
            state_q          <= (idx_q == 2'd3) ? ST_FIN : ST_PMUL;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            m_data_q  <= {7'b0, res_trip_q,
                          res_dir_q[3], res_dir_q[2], res_dir_q[1], res_dir_q[0],
                          res_pwm_q[3], res_pwm_q[2], res_pwm_q[1], res_pwm_q[0]};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  mwpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `MWPM_ASSERT(a_stop_goes_fin, (s_accept && in_op == OP_STOP) |=> state_q == ST_FIN)
  `MWPM_ASSERT(a_trip_field, $rose(m_valid_q) |-> m_data_q[72] == trip_q)
  `MWPM_ASSERT_NEVER(a_div_done_stray,
    div_done && !(state_q == ST_MIX_WAIT || state_q == ST_PWAIT))
endmodule

// ===== tb/tb_mecanum_wheel_pwm_mixer_top.sv =====
// Self-checking testbench for the mecanum wheel PWM mixer top level.
`timescale 1ns / 100ps
module tb_mecanum_wheel_pwm_mixer_top;
  import mwpm_pkg::*;

  // One command transaction: fields laid out exactly as in s_axis_tdata_i
  // (vel_x lowest), op on top; op goes out on tuser.
  typedef struct packed {
    logic [2:0]        op;
    logic              en;
    logic [31:0]       now;
    logic [3:0][23:0]  spd;   // lf, rf, lr, rr from the low end
    logic [15:0]       yaw;
    logic [15:0]       vy;
    logic [15:0]       vx;
  } cmd_t;

  // One motor result: matches m_axis_tdata_o[72:0].
  typedef struct packed {
    logic              trip;
    logic [3:0][1:0]   dir;
    logic [3:0][15:0]  pwm;
  } motor_t;

  localparam int SETTLE_CYCLES = 400;  // longer than the longest command

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // vel_x, vel_y, yaw_rate, speed_lf, speed_rf, speed_lr, speed_rr, now_ms,
  // enable_value, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  // op
  logic [2:0]            s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // pwm_lf, pwm_rf, pwm_lr, pwm_rr, dir_lf, dir_rf, dir_lr, dir_rr,
  // watchdog_tripped, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  mecanum_wheel_pwm_mixer_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the mixer configuration and state.
  logic [15:0] radius_q, full_q, dead_q;
  logic [17:0] lever_q;
  logic [22:0] maxspd_q;
  logic [31:0] timeout_q, last_cmd_ms;
  logic [3:0]  invert_q;
  logic        drive_on, wd_tripped;

  cmd_t   cmd_queue[$];
  motor_t motor_expected[$];
  cmd_t   cur_cmd;
  int     n_errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  logic [31:0] clock_ms = '0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic motor_t stop_motors();
    motor_t m;
    m      = '0;
    m.trip = wd_tripped;
    return m;
  endfunction

  // Wheel speed from one mixed numerator, rounded half away from zero,
  // saturated to 24 bits.
  function automatic longint mix_speed(input longint lin, input longint rot,
                                       input longint unsigned dv);
    longint n;
    longint unsigned mag, q;
    n   = lin * 65536 + rot;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q   = (mag + dv / 2) / dv;
    if (n < 0) begin
      if (q > 64'd8388608) q = 64'd8388608;
      return -longint'(q);
    end
    if (q > 64'd8388607) q = 64'd8388607;
    return longint'(q);
  endfunction

  task automatic drive_wheels(input longint w[4], input logic [31:0] now);
    longint unsigned mag[4];
    longint unsigned peak, d, p;
    logic fwd;
    motor_t m;
    last_cmd_ms = now;
    wd_tripped  = 1'b0;
    if (!drive_on) begin
      motor_expected.push_back(stop_motors());
      return;
    end
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (w[i] < 0) ? longint'(-w[i]) : longint'(w[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    d = (longint'(maxspd_q) > peak) ? longint'(maxspd_q) : peak;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      p = (d != 0) ? (2 * mag[i] * full_q + d) / (2 * d) : 0;
      if (p > 64'hFFFF) p = 64'hFFFF;
      if (p < dead_q) p = 0;
      m.pwm[i] = p[15:0];
      if (p == 0) begin
        m.dir[i] = DIR_STOP;
      end else begin
        fwd = (w[i] >= 0) ^ invert_q[i];
        m.dir[i] = fwd ? DIR_FWD : DIR_REV;
      end
    end
    motor_expected.push_back(m);
  endtask

  // Expected outcome of one accepted command.
  task automatic predict_motors(input cmd_t c);
    longint w[4];
    longint rot, vx, vy;
    longint unsigned dv;
    vx  = longint'($signed(c.vx));
    vy  = longint'($signed(c.vy));
    rot = longint'(lever_q) * longint'($signed(c.yaw));
    dv  = 16 * ((radius_q == 0) ? 64'd1 : longint'(radius_q));
    case (c.op)
      OP_BODY: begin
        w[0] = mix_speed(vx - vy, -rot, dv);
        w[1] = mix_speed(vx + vy, rot, dv);
        w[2] = mix_speed(vx + vy, -rot, dv);
        w[3] = mix_speed(vx - vy, rot, dv);
        drive_wheels(w, c.now);
      end
      OP_WHEELS: begin
        for (int i = 0; i < 4; i++) w[i] = longint'($signed(c.spd[i]));
        drive_wheels(w, c.now);
      end
      OP_TIME: begin
        if (timeout_q != 0 && (c.now - last_cmd_ms) >= timeout_q) begin
          wd_tripped = 1'b1;
          motor_expected.push_back(stop_motors());
        end
      end
      OP_ENABLE: begin
        drive_on = c.en;
        if (!c.en) motor_expected.push_back(stop_motors());
      end
      OP_STOP: motor_expected.push_back(stop_motors());
      default: ;  // undefined op: ignored by the block
    endcase
  endtask

  // Driver: presents queued commands, with random gaps when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      m_axis_tready_i <= 1'b0;
    end else begin
      busy = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_motors(cur_cmd);
        busy = 1'b0;
      end
      if (!busy) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          s_axis_tdata_i  <= {7'b0, cur_cmd[176:0]};
          s_axis_tuser_i  <= cur_cmd.op;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    motor_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[72:0];
      if (motor_expected.size() == 0) begin
        report("unexpected result", {8'b0, got[72:64], 15'b0}, '0);
      end else begin
        want = motor_expected.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.pwm[i] !== want.pwm[i]) report($sformatf("pwm[%0d]", i), got.pwm[i], want.pwm[i]);
          if (got.dir[i] !== want.dir[i]) report($sformatf("dir[%0d]", i), got.dir[i], want.dir[i]);
        end
        if (got.trip !== want.trip) report("watchdog_tripped", got.trip, want.trip);
      end
    end
  end

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_RADIUS:   radius_q  = val[15:0];
      REG_LEVER:    lever_q   = val[17:0];
      REG_MAXSPD:   maxspd_q  = val[22:0];
      REG_FULL:     full_q    = val[15:0];
      REG_DEADBAND: dead_q    = val[15:0];
      REG_TIMEOUT:  timeout_q = val;
      default:      invert_q  = val[3:0];
    endcase
  endtask

  task automatic set_config(input logic [31:0] r, l, ms, f, db, to, inv);
    write_reg(REG_RADIUS, r);
    write_reg(REG_LEVER, l);
    write_reg(REG_MAXSPD, ms);
    write_reg(REG_FULL, f);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_TIMEOUT, to);
    write_reg(REG_INVERT, inv);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for all queued commands to go in and every result to come back.
  task automatic drain();
    wait (cmd_queue.size() == 0 && !s_axis_tvalid_i && motor_expected.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(input logic [2:0] op, input logic [15:0] vx, vy, yaw,
                              input logic [95:0] spd, input logic [31:0] now,
                              input logic en);
    cmd_t c;
    c.op = op; c.vx = vx; c.vy = vy; c.yaw = yaw;
    c.spd = spd; c.now = now; c.en = en;
    return c;
  endfunction

  // Random command: mostly commands and watchdog checks with a clock that
  // mostly creeps forward, sometimes jumps anywhere.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int sel;
    c = $bits(cmd_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 35)      c.op = OP_BODY;
    else if (sel < 65) c.op = OP_WHEELS;
    else if (sel < 85) c.op = OP_TIME;
    else if (sel < 92) c.op = OP_ENABLE;
    else if (sel < 97) c.op = OP_STOP;
    else               c.op = 3'($urandom_range(5, 7));
    if ($urandom_range(1)) begin
      c.vx  = 16'($urandom_range(16383) - 8192);
      c.vy  = 16'($urandom_range(16383) - 8192);
      c.yaw = 16'($urandom_range(16383) - 8192);
    end
    if ($urandom_range(1))
      for (int i = 0; i < 4; i++) c.spd[i] = 24'($urandom_range(32767) - 16384);
    if (c.op == OP_ENABLE) c.en = ($urandom_range(9) < 7);
    if ($urandom_range(9) < 8) clock_ms += $urandom_range(1500);
    else clock_ms = $urandom;
    c.now = clock_ms;
    return c;
  endfunction

  initial begin
    logic [31:0] rad, lev, mxs, ful, ddb, tmo, inv;
    radius_q = RST_RADIUS;  lever_q = RST_LEVER;   maxspd_q = RST_MAXSPD;
    full_q   = RST_FULL;    dead_q  = RST_DEADBAND; timeout_q = RST_TIMEOUT;
    invert_q = RST_INVERT;  drive_on = 1'b1; wd_tripped = 1'b0; last_cmd_ms = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on reset configuration.
    cmd_queue.push_back(mk(OP_BODY, 16'h0000, 16'h0000, 16'h0000, '0, 32'd10, 1'b0));
    cmd_queue.push_back(mk(OP_BODY, 16'h7FFF, 16'h0000, 16'h0000, '0, 32'd20, 1'b0));
    cmd_queue.push_back(mk(OP_BODY, 16'h8000, 16'h8000, 16'h8000, '0, 32'd30, 1'b0));
    cmd_queue.push_back(mk(OP_BODY, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0, 32'd40, 1'b0));
    cmd_queue.push_back(mk(OP_BODY, 16'h0400, 16'hFE00, 16'h0100, '0, 32'd50, 1'b0));
    cmd_queue.push_back(mk(OP_WHEELS, '0, '0, '0, {24'h7FFFFF, 24'h800000,
                           24'h000001, 24'hFFFFFF}, 32'd60, 1'b0));
    cmd_queue.push_back(mk(OP_WHEELS, '0, '0, '0, '0, 32'd70, 1'b0));
    cmd_queue.push_back(mk(OP_WHEELS, '0, '0, '0, {24'd1000, 24'hFFF000,
                           24'd7680, 24'd3}, 32'd80, 1'b0));
    cmd_queue.push_back(mk(OP_TIME, '0, '0, '0, '0, 32'd2079, 1'b0));   // just inside
    cmd_queue.push_back(mk(OP_TIME, '0, '0, '0, '0, 32'd2080, 1'b0));   // trips
    cmd_queue.push_back(mk(OP_TIME, '0, '0, '0, '0, 32'hFFFFFFFF, 1'b0)); // trips again
    cmd_queue.push_back(mk(OP_STOP, '0, '0, '0, '0, '0, 1'b1));         // flag kept
    cmd_queue.push_back(mk(OP_ENABLE, '0, '0, '0, '0, '0, 1'b0));
    cmd_queue.push_back(mk(OP_WHEELS, '0, '0, '0, {4{24'd500}}, 32'd100, 1'b0));
    cmd_queue.push_back(mk(OP_ENABLE, '0, '0, '0, '0, '0, 1'b1));
    cmd_queue.push_back(mk(3'd5, '1, '1, '1, '1, '1, 1'b1));
    cmd_queue.push_back(mk(3'd7, '1, '1, '1, '1, '1, 1'b1));
    cmd_queue.push_back(mk(OP_TIME, '0, '0, '0, '0, 32'd50, 1'b0));     // wrapped elapsed
    cmd_queue.push_back(mk(OP_BODY, 16'h1000, 16'h0000, 16'h0000, '0, 32'd200, 1'b0));
    drain();

    // Random phases; the first few pin register extremes, the rest are random.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin rad = 0;     lev = 0;      mxs = 0;       ful = 1;
                 ddb = 0;     tmo = 0;      inv = 15; end
        1: begin rad = 65535; lev = 262143; mxs = 8388607; ful = 65535;
                 ddb = 65535; tmo = 32'hFFFFFFFF; inv = 0; end
        2: begin rad = 1;     lev = 262143; mxs = 1;       ful = 65535;
                 ddb = 300;   tmo = 1;      inv = 5; end
        3: begin rad = RST_RADIUS; lev = RST_LEVER; mxs = RST_MAXSPD; ful = RST_FULL;
                 ddb = 10;    tmo = 1000;   inv = 10; end
        default: begin
          rad = $urandom_range(65535); lev = $urandom_range(262143);
          mxs = $urandom_range(1, 8388607) >> $urandom_range(12);
          ful = $urandom_range(1, 65535); ddb = $urandom_range(3) == 0 ? $urandom_range(65535)
                                                                      : $urandom_range(50);
          tmo = $urandom_range(1, 4000); inv = $urandom_range(15);
        end
      endcase
      set_config(rad, lev, mxs, ful, ddb, tmo, inv);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int i = 0; i < 245; i++) cmd_queue.push_back(random_cmd());
      drain();
    end

    if (n_errors == 0) begin
      $display("** mecanum_wheel_pwm_mixer_top: PASSED **");
    end else begin
      $display("** mecanum_wheel_pwm_mixer_top: FAILED **");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #60ms;
    $display("** mecanum_wheel_pwm_mixer_top: FAILED **");
    $finish;
  end

endmodule

// ===== mecanum_wheel_pwm_mixer_top.f =====
+incdir+sv
sv/mwpm_pkg.sv
sv/mwpm_div.sv
sv/mecanum_wheel_pwm_mixer_top.sv
tb/tb_mecanum_wheel_pwm_mixer_top.sv
